>>> sv/gwdm_pkg.sv
// Shared constants, codes and types of the grid weighted distance map.
`timescale 1ns / 1ps

package gwdm_pkg;

  localparam int GRID_W_DEF    = 32;
  localparam int GRID_H_DEF    = 32;
  localparam int DIST_BITS_DEF = 16;
  localparam int DEPTH_DEF     = GRID_W_DEF * GRID_H_DEF;

  // Cell word: {blocked, occupied, cost}.
  localparam int COST_BITS = 8;
  localparam int CELL_BITS = COST_BITS + 2;
  localparam int PEN_BITS  = 10;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PENALTY     = 3'd2;
  localparam logic [2:0] REG_MOVE_RANGE  = 3'd3;
  localparam logic [2:0] REG_HIGHLIGHT   = 3'd4;

  localparam logic [5:0]  GRID_WIDTH_RST  = 6'd32;
  localparam logic [5:0]  GRID_HEIGHT_RST = 6'd32;
  localparam logic [9:0]  PENALTY_RST     = 10'd999;
  localparam logic [15:0] MOVE_RANGE_RST  = 16'd0;

  // Phase of the per-cell relaxation; each but PH_EVAL names the read issued in it.
  localparam logic [2:0] PH_SELF  = 3'd0;
  localparam logic [2:0] PH_RIGHT = 3'd1;
  localparam logic [2:0] PH_LEFT  = 3'd2;
  localparam logic [2:0] PH_DOWN  = 3'd3;
  localparam logic [2:0] PH_UP    = 3'd4;
  localparam logic [2:0] PH_EVAL  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_RELAX,
    ST_DONE
  } state_t;

endpackage

>>> sv/gwdm_if.sv
// Valid/ready channel interfaces for the command and result words.
`timescale 1ns / 1ps

interface gwdm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [4:0] cell_x;
  logic [4:0] cell_y;
  logic [7:0] step_cost;
  logic       blocked;
  logic       occupied;

  modport source (output valid, op, cell_x, cell_y, step_cost, blocked, occupied,
                  input ready);
  modport sink (input valid, op, cell_x, cell_y, step_cost, blocked, occupied,
                output ready);
endinterface

interface gwdm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic        in_range;
  logic        done_res;

  modport source (output valid, distance, in_range, done_res, input ready);
  modport sink (input valid, distance, in_range, done_res, output ready);
endinterface

>>> sv/gwdm_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module gwdm_ram #(
  parameter int WIDTH = gwdm_pkg::CELL_BITS,
  parameter int DEPTH = gwdm_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/grid_weighted_distance_map_core.sv
// Top level of the grid weighted distance map: control, registers and memories.
//
// Commands arrive as words on in_if; results leave as words on out_if.
// A write word stores one cell (cost, blocked, occupied).
// A read word returns a word once ST_READ has registered it: the distance
// of the cell and its in-range flag, judged with the registers at that time.
// A compute word first sweeps the distance memory, one entry per cycle,
// then relaxes the area in use in raster sweeps.
// Each cell of a sweep steps through phases PH_SELF to PH_UP, one per read
// of the single distance read port (the cell itself and its four neighbors),
// then PH_EVAL; sweeps repeat until a whole sweep lowers no distance, and
// none runs when the start lies outside the area in use.
// Its result word carries done_res and the start cell's distance.
// One command is worked on at a time; in_if.ready is low while a command
// runs and while an unread result word stalls on out_if.
// After reset the registers take their reset values and every read returns
// the maximum distance until the first compute; no clearing pass is run.
// Configuration is written through cfg_we/cfg_index/cfg_wdata by the user,
// only when idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module grid_weighted_distance_map_core #(
  parameter int GRID_W    = gwdm_pkg::GRID_W_DEF,
  parameter int GRID_H    = gwdm_pkg::GRID_H_DEF,
  parameter int DIST_BITS = gwdm_pkg::DIST_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gwdm_in_if.sink           in_if,
  gwdm_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int XB    = $clog2(GRID_W);
  localparam int YB    = $clog2(GRID_H);
  localparam int DB    = DIST_BITS;
  localparam int SB    = ((DB > gwdm_pkg::PEN_BITS) ? DB : gwdm_pkg::PEN_BITS) + 1;
  localparam logic [DB-1:0] DIST_MAX = '1;

  // Configuration registers.
  logic [5:0]  cfg_w_r, cfg_h_r;
  logic [9:0]  cfg_pen_r;
  logic [15:0] cfg_range_r;
  logic        cfg_hl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= gwdm_pkg::GRID_WIDTH_RST;
      cfg_h_r     <= gwdm_pkg::GRID_HEIGHT_RST;
      cfg_pen_r   <= gwdm_pkg::PENALTY_RST;
      cfg_range_r <= gwdm_pkg::MOVE_RANGE_RST;
      cfg_hl_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        gwdm_pkg::REG_GRID_WIDTH:  cfg_w_r     <= cfg_wdata[5:0];
        gwdm_pkg::REG_GRID_HEIGHT: cfg_h_r     <= cfg_wdata[5:0];
        gwdm_pkg::REG_PENALTY:     cfg_pen_r   <= cfg_wdata[9:0];
        gwdm_pkg::REG_MOVE_RANGE:  cfg_range_r <= cfg_wdata;
        gwdm_pkg::REG_HIGHLIGHT:   cfg_hl_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Area in use.
  logic [8:0] w9, h9, eff_w, eff_h;
  assign w9    = 9'(cfg_w_r);
  assign h9    = 9'(cfg_h_r);
  assign eff_w = (w9 == 9'd0) ? 9'd1 : ((w9 > 9'(GRID_W)) ? 9'(GRID_W) : w9);
  assign eff_h = (h9 == 9'd0) ? 9'd1 : ((h9 > 9'(GRID_H)) ? 9'(GRID_H) : h9);

  // Input word decode.
  logic [8:0]    in_x9, in_y9;
  logic [AW-1:0] in_addr;
  logic          in_grid, in_area, in_ready, accept;
  assign in_x9   = 9'(in_if.cell_x);
  assign in_y9   = 9'(in_if.cell_y);
  assign in_addr = AW'(in_y9 * GRID_W + in_x9);
  assign in_grid = (in_x9 < 9'(GRID_W)) && (in_y9 < 9'(GRID_H));
  assign in_area = (in_x9 < eff_w) && (in_y9 < eff_h);
  assign accept  = in_if.valid && in_ready;

  // Control state.
  gwdm_pkg::state_t state_r, state_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [XB-1:0] sx_r, sx_nxt;
  logic [YB-1:0] sy_r, sy_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic          changed_r, changed_nxt;
  logic [DB-1:0] dc_r, dc_nxt;
  logic [DB-1:0] nb_r, nb_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic          start_valid_r, start_valid_nxt;
  logic          start_ok_r, start_ok_nxt;
  logic          computed_r, computed_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_dist_r, out_dist_nxt;
  logic          out_rng_r, out_rng_nxt;
  logic          out_done_r, out_done_nxt;

  assign in_ready    = (state_r == gwdm_pkg::ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_if.ready = in_ready;

  // Memory ports.
  logic                          cell_we;
  logic [gwdm_pkg::CELL_BITS-1:0] cell_rdata;
  logic                          dist_we;
  logic [AW-1:0]                 dist_waddr, dist_raddr;
  logic [DB-1:0]                 dist_wdata, dist_rdata;

  logic [AW-1:0] cur;
  assign cur = AW'(sy_r * GRID_W + sx_r);

  assign cell_we = accept && (in_if.op == gwdm_pkg::OP_WRITE) && in_grid;

  gwdm_ram #(.WIDTH(gwdm_pkg::CELL_BITS), .DEPTH(CELLS)) u_cell_mem (
    .clk   (clk),
    .we    (cell_we),
    .waddr (in_addr),
    .wdata ({in_if.blocked, in_if.occupied, in_if.step_cost}),
    .raddr (cur),
    .rdata (cell_rdata)
  );

  gwdm_ram #(.WIDTH(DB), .DEPTH(CELLS)) u_dist_mem (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  // Neighbor existence inside the area in use.
  logic right_ok, left_ok, down_ok, up_ok;
  assign right_ok = (9'(sx_r) + 9'd1) < eff_w;
  assign left_ok  = sx_r != '0;
  assign down_ok  = (9'(sy_r) + 9'd1) < eff_h;
  assign up_ok    = sy_r != '0;

  // Relaxation of the current cell from its best neighbor.
  logic [DB-1:0]                 up_d, nb_min, cand, rd_d;
  logic [gwdm_pkg::PEN_BITS-1:0] step;
  logic [SB-1:0]                 sum;
  logic                          improve, last_cell;
  assign up_d   = up_ok ? dist_rdata : DIST_MAX;
  assign nb_min = (up_d < nb_r) ? up_d : nb_r;
  assign step   = cell_rdata[gwdm_pkg::COST_BITS] ? cfg_pen_r
                                                  : 10'(cell_rdata[gwdm_pkg::COST_BITS-1:0]);
  assign sum    = SB'(nb_min) + SB'(step);
  assign cand   = (sum > SB'(DIST_MAX)) ? DIST_MAX : DB'(sum);
  // A blocked cell is never entered; the start stays at zero. A cell with no
  // reached neighbor cannot improve, so its cell word is not looked at.
  assign improve = (nb_min != DIST_MAX) && !cell_rdata[gwdm_pkg::CELL_BITS-1] &&
                   (cur != start_r) && (cand < dc_r);
  assign last_cell = !right_ok && !down_ok;
  assign rd_d = (rd_ok_r && computed_r) ? dist_rdata : DIST_MAX;

  always_comb begin
    state_nxt       = state_r;
    ph_nxt          = ph_r;
    sx_nxt          = sx_r;
    sy_nxt          = sy_r;
    fill_nxt        = fill_r;
    changed_nxt     = changed_r;
    dc_nxt          = dc_r;
    nb_nxt          = nb_r;
    start_nxt       = start_r;
    start_valid_nxt = start_valid_r;
    start_ok_nxt    = start_ok_r;
    computed_nxt    = computed_r;
    rd_ok_nxt       = rd_ok_r;
    rd_addr_nxt     = rd_addr_r;
    out_valid_nxt   = out_valid_r;
    out_dist_nxt    = out_dist_r;
    out_rng_nxt     = out_rng_r;
    out_done_nxt    = out_done_r;
    dist_we         = 1'b0;
    dist_waddr      = cur;
    dist_wdata      = DIST_MAX;
    dist_raddr      = cur;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gwdm_pkg::ST_IDLE: begin
        dist_raddr  = in_addr;
        if (accept) begin
          case (in_if.op)
            gwdm_pkg::OP_COMPUTE: begin
              start_ok_nxt = in_area;
              computed_nxt = 1'b1;
              fill_nxt     = '0;
              if (in_area) begin
                start_nxt       = in_addr;
                start_valid_nxt = 1'b1;
              end
              state_nxt = gwdm_pkg::ST_FILL;
            end
            gwdm_pkg::OP_READ: begin
              rd_ok_nxt   = in_area;
              rd_addr_nxt = in_addr;
              state_nxt   = gwdm_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      gwdm_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = 16'(rd_d);
        out_rng_nxt   = cfg_hl_r && rd_ok_r && !(start_valid_r && rd_addr_r == start_r) &&
                        (rd_d != DIST_MAX) && (33'(rd_d) <= 33'(cfg_range_r));
        out_done_nxt  = 1'b0;
        state_nxt     = gwdm_pkg::ST_IDLE;
      end
      gwdm_pkg::ST_FILL: begin
        dist_we    = 1'b1;
        dist_waddr = fill_r;
        dist_wdata = (start_ok_r && fill_r == start_r) ? '0 : DIST_MAX;
        if (fill_r == AW'(CELLS - 1)) begin
          sx_nxt      = '0;
          sy_nxt      = '0;
          ph_nxt      = gwdm_pkg::PH_SELF;
          changed_nxt = 1'b0;
          state_nxt   = start_ok_r ? gwdm_pkg::ST_RELAX : gwdm_pkg::ST_DONE;
        end else begin
          fill_nxt = fill_r + AW'(1);
        end
      end
      gwdm_pkg::ST_RELAX: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          gwdm_pkg::PH_SELF: begin
            dist_raddr = cur;
          end
          gwdm_pkg::PH_RIGHT: begin
            dc_nxt     = dist_rdata;
            dist_raddr = cur + AW'(1);
          end
          gwdm_pkg::PH_LEFT: begin
            nb_nxt     = right_ok ? dist_rdata : DIST_MAX;
            dist_raddr = cur - AW'(1);
          end
          gwdm_pkg::PH_DOWN: begin
            if (left_ok && dist_rdata < nb_r) nb_nxt = dist_rdata;
            dist_raddr = cur + AW'(GRID_W);
          end
          gwdm_pkg::PH_UP: begin
            if (down_ok && dist_rdata < nb_r) nb_nxt = dist_rdata;
            dist_raddr = cur - AW'(GRID_W);
          end
          gwdm_pkg::PH_EVAL: begin
            ph_nxt = gwdm_pkg::PH_SELF;
            if (improve) begin
              dist_we    = 1'b1;
              dist_waddr = cur;
              dist_wdata = cand;
            end
            if (right_ok) begin
              sx_nxt = sx_r + XB'(1);
            end else begin
              sx_nxt = '0;
              sy_nxt = sy_r + YB'(1);
            end
            changed_nxt = changed_r || improve;
            if (last_cell) begin
              // Sweep again until a whole sweep lowers nothing.
              sy_nxt      = '0;
              changed_nxt = 1'b0;
              if (!(changed_r || improve)) state_nxt = gwdm_pkg::ST_DONE;
            end
          end
          default: ph_nxt = gwdm_pkg::PH_SELF;
        endcase
      end
      gwdm_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = start_ok_r ? 16'd0 : 16'(DIST_MAX);
        out_rng_nxt   = 1'b0;
        out_done_nxt  = 1'b1;
        state_nxt     = gwdm_pkg::ST_IDLE;
      end
      default: state_nxt = gwdm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gwdm_pkg::ST_IDLE;
      ph_r          <= gwdm_pkg::PH_SELF;
      start_r       <= '0;
      start_valid_r <= 1'b0;
      computed_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ph_r          <= ph_nxt;
      start_r       <= start_nxt;
      start_valid_r <= start_valid_nxt;
      computed_r    <= computed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    fill_r     <= fill_nxt;
    changed_r  <= changed_nxt;
    dc_r       <= dc_nxt;
    nb_r       <= nb_nxt;
    start_ok_r <= start_ok_nxt;
    rd_ok_r    <= rd_ok_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_dist_r <= out_dist_nxt;
    out_rng_r  <= out_rng_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.distance = out_dist_r;
  assign out_if.in_range = out_rng_r;
  assign out_if.done_res = out_done_r;

  // The start cell is never rewritten while relaxing.
  a_start_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_we && state_r == gwdm_pkg::ST_RELAX) |-> (dist_waddr != start_r))
    else $error("relaxation wrote the start cell");

  // Relaxation only ever lowers a distance.
  a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_we && state_r == gwdm_pkg::ST_RELAX) |-> (dist_wdata < dc_r))
    else $error("relaxation raised a distance");

  // A compute result never carries an in-range flag.
  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.done_res) |-> !out_if.in_range)
    else $error("compute result flagged in range");

  // A read word has its result word waiting after ST_READ has registered it.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_if.op == gwdm_pkg::OP_READ) |=> ##1 (out_if.valid && !out_if.done_res))
    else $error("read result missing");

endmodule

>>> test/gwdm_checker.sv
// Watches the channels of the distance map, predicts every result word and compares.
`timescale 1ns / 1ps

module gwdm_checker (
  input  logic        clk,
  input  logic        rst_n,
  gwdm_in_if          in_mon,
  gwdm_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          waiting_count
);

  localparam int NCELL = gwdm_pkg::GRID_W_DEF * gwdm_pkg::GRID_H_DEF;
  localparam int DMAX  = (1 << gwdm_pkg::DIST_BITS_DEF) - 1;

  typedef struct packed {
    logic [15:0] distance;
    logic        in_range;
    logic        done_res;
  } map_result_t;

  map_result_t result_q[$];

  logic [7:0] cost_mem[NCELL];
  bit         wall_mem[NCELL];
  bit         occ_mem[NCELL];
  int         dist_mem[NCELL];
  bit         dirty_mem[NCELL];
  int         origin;
  bit         origin_ok;

  logic [5:0]  width_reg;
  logic [5:0]  height_reg;
  logic [9:0]  penalty_reg;
  logic [15:0] range_reg;
  logic        hilite_reg;

  function automatic int area_w();
    if (width_reg == 0) return 1;
    return (width_reg > gwdm_pkg::GRID_W_DEF) ? gwdm_pkg::GRID_W_DEF : int'(width_reg);
  endfunction

  function automatic int area_h();
    if (height_reg == 0) return 1;
    return (height_reg > gwdm_pkg::GRID_H_DEF) ? gwdm_pkg::GRID_H_DEF : int'(height_reg);
  endfunction

  // Offers cell src's distance plus the entry cost to cell dst.
  function automatic bit offer(int src, int dst);
    int step;
    int cand;
    if (wall_mem[dst]) return 0;
    step = occ_mem[dst] ? int'(penalty_reg) : int'(cost_mem[dst]);
    cand = dist_mem[src] + step;
    if (cand > DMAX) cand = DMAX;
    if (dist_mem[dst] > cand) begin
      dist_mem[dst] = cand;
      dirty_mem[dst] = 1;
      return 1;
    end
    return 0;
  endfunction

  function automatic void flood_from(int sx, int sy);
    int w;
    int h;
    int c;
    bit busy;
    w = area_w();
    h = area_h();
    for (int k = 0; k < NCELL; k++) begin
      dist_mem[k] = DMAX;
      dirty_mem[k] = 0;
    end
    if (sx >= w || sy >= h) return;
    origin = sy * gwdm_pkg::GRID_W_DEF + sx;
    origin_ok = 1;
    dist_mem[origin] = 0;
    dirty_mem[origin] = 1;
    busy = 1;
    while (busy) begin
      busy = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          c = y * gwdm_pkg::GRID_W_DEF + x;
          if (dirty_mem[c]) begin
            dirty_mem[c] = 0;
            busy = 1;
            if (x + 1 < w) void'(offer(c, c + 1));
            if (x > 0) void'(offer(c, c - 1));
            if (y + 1 < h) void'(offer(c, c + gwdm_pkg::GRID_W_DEF));
            if (y > 0) void'(offer(c, c - gwdm_pkg::GRID_W_DEF));
          end
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    map_result_t exp_r;
    map_result_t got_r;
    int c;
    int d;
    if (!rst_n) begin
      width_reg   = gwdm_pkg::GRID_WIDTH_RST;
      height_reg  = gwdm_pkg::GRID_HEIGHT_RST;
      penalty_reg = gwdm_pkg::PENALTY_RST;
      range_reg   = gwdm_pkg::MOVE_RANGE_RST;
      hilite_reg  = 1'b1;
      for (int k = 0; k < NCELL; k++) begin
        cost_mem[k] = '0;
        wall_mem[k] = 0;
        occ_mem[k] = 0;
        dist_mem[k] = DMAX;
        dirty_mem[k] = 0;
      end
      origin = 0;
      origin_ok = 0;
      result_q.delete();
      fail_count = 0;
    end else begin
      // The result side is checked first so that a word predicted at this edge
      // cannot be matched against one leaving at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        got_r = '{out_mon.distance, out_mon.in_range, out_mon.done_res};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, got_r);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (got_r.distance !== exp_r.distance)
            $display("%0t: distance expected %0d actual %0d", $time,
                     exp_r.distance, got_r.distance);
          if (got_r.in_range !== exp_r.in_range)
            $display("%0t: in_range expected %0b actual %0b", $time,
                     exp_r.in_range, got_r.in_range);
          if (got_r.done_res !== exp_r.done_res)
            $display("%0t: done_res expected %0b actual %0b", $time,
                     exp_r.done_res, got_r.done_res);
          if (got_r !== exp_r) fail_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          gwdm_pkg::REG_GRID_WIDTH:  width_reg   = cfg_wdata[5:0];
          gwdm_pkg::REG_GRID_HEIGHT: height_reg  = cfg_wdata[5:0];
          gwdm_pkg::REG_PENALTY:     penalty_reg = cfg_wdata[9:0];
          gwdm_pkg::REG_MOVE_RANGE:  range_reg   = cfg_wdata;
          gwdm_pkg::REG_HIGHLIGHT:   hilite_reg  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        c = int'(in_mon.cell_y) * gwdm_pkg::GRID_W_DEF + int'(in_mon.cell_x);
        case (in_mon.op)
          gwdm_pkg::OP_WRITE: begin
            cost_mem[c] = in_mon.step_cost;
            wall_mem[c] = in_mon.blocked;
            occ_mem[c] = in_mon.occupied;
          end
          gwdm_pkg::OP_COMPUTE: begin
            flood_from(in_mon.cell_x, in_mon.cell_y);
            d = DMAX;
            if (in_mon.cell_x < area_w() && in_mon.cell_y < area_h()) d = dist_mem[c];
            exp_r = '{d[15:0], 1'b0, 1'b1};
            result_q.insert(result_q.size(), exp_r);
          end
          gwdm_pkg::OP_READ: begin
            exp_r = '{16'hFFFF, 1'b0, 1'b0};
            if (in_mon.cell_x < area_w() && in_mon.cell_y < area_h()) begin
              exp_r.distance = dist_mem[c][15:0];
              exp_r.in_range = hilite_reg && !(origin_ok && c == origin) &&
                               dist_mem[c] < DMAX && dist_mem[c] <= int'(range_reg);
            end
            result_q.insert(result_q.size(), exp_r);
          end
          default: ;
        endcase
      end
    end
    waiting_count = result_q.size();
  end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for the grid weighted distance map core.
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          waiting_count;
  int          stall_left;

  gwdm_in_if  in_if ();
  gwdm_out_if out_if ();

  grid_weighted_distance_map_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gwdm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .waiting_count (waiting_count)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side back-pressure; some stretches run without any stall.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_word(logic [1:0] op, logic [4:0] x, logic [4:0] y,
                           logic [7:0] cost, logic blk, logic occ);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.cell_x = x;
    in_if.cell_y = y;
    in_if.step_cost = cost;
    in_if.blocked = blk;
    in_if.occupied = occ;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (waiting_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_area(int w, int h);
    write_reg(gwdm_pkg::REG_GRID_WIDTH, 16'(w));
    write_reg(gwdm_pkg::REG_GRID_HEIGHT, 16'(h));
  endtask

  task automatic random_cell_write(int x, int y);
    send_word(gwdm_pkg::OP_WRITE, 5'(x), 5'(y), 8'($urandom_range(0, 255)),
              ($urandom_range(0, 6) == 0), ($urandom_range(0, 9) == 0));
  endtask

  initial begin
    int w;
    int h;
    int r;
    cfg_we = 1'b0;
    cfg_index = gwdm_pkg::REG_GRID_WIDTH;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.op = gwdm_pkg::OP_WRITE;
    in_if.cell_x = '0;
    in_if.cell_y = '0;
    in_if.step_cost = '0;
    in_if.blocked = 1'b0;
    in_if.occupied = 1'b0;
    out_if.ready = 1'b0;
    stall_left = 0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Before any compute every read returns the maximum; op 3 is dropped.
    send_word(gwdm_pkg::OP_READ, 5'd31, 5'd31, 8'd0, 1'b0, 1'b0);
    send_word(2'd3, 5'd7, 5'd9, 8'hFF, 1'b1, 1'b1);
    send_word(gwdm_pkg::OP_READ, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0);

    // Load an 8 by 8 corner block and wall it in, so that no compute can
    // reach a cell whose cost was never written.
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++) random_cell_write(x, y);
    for (int k = 0; k < 9; k++) begin
      send_word(gwdm_pkg::OP_WRITE, 5'd8, 5'(k), 8'd1, 1'b1, 1'b0);
      if (k < 8) send_word(gwdm_pkg::OP_WRITE, 5'(k), 5'd8, 8'd1, 1'b1, 1'b0);
    end
    send_word(gwdm_pkg::OP_WRITE, 5'd0, 5'd0, 8'd255, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_WRITE, 5'd31, 5'd31, 8'd0, 1'b0, 1'b1);

    // Full grid, start at the origin corner, default registers.
    send_word(gwdm_pkg::OP_COMPUTE, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd31, 5'd31, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd1, 5'd0, 8'd0, 1'b0, 1'b0);
    settle();

    // Oversized area registers clamp to the grid; range covers everything.
    set_area(63, 63);
    write_reg(gwdm_pkg::REG_MOVE_RANGE, 16'hFFFF);
    write_reg(gwdm_pkg::REG_PENALTY, 16'd0);
    send_word(gwdm_pkg::OP_READ, 5'd16, 5'd31, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_COMPUTE, 5'd5, 5'd6, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd0, 5'd31, 8'd0, 1'b0, 1'b0);
    settle();

    // A zero area acts as one cell; a start outside the area gives the maximum.
    set_area(0, 0);
    write_reg(gwdm_pkg::REG_PENALTY, 16'd1023);
    send_word(gwdm_pkg::OP_COMPUTE, 5'd1, 5'd0, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_COMPUTE, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0);
    settle();

    // A blocked start still gets distance zero; highlighting switched off.
    set_area(3, 2);
    write_reg(gwdm_pkg::REG_HIGHLIGHT, 16'd0);
    send_word(gwdm_pkg::OP_WRITE, 5'd1, 5'd1, 8'd5, 1'b1, 1'b0);
    send_word(gwdm_pkg::OP_COMPUTE, 5'd1, 5'd1, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd2, 5'd1, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd3, 5'd1, 8'd0, 1'b0, 1'b0);
    settle();
    write_reg(gwdm_pkg::REG_HIGHLIGHT, 16'd1);
    send_word(gwdm_pkg::OP_READ, 5'd2, 5'd1, 8'd0, 1'b0, 1'b0);
    send_word(gwdm_pkg::OP_READ, 5'd1, 5'd1, 8'd0, 1'b0, 1'b0);
    settle();

    // Random phases on small areas with fresh register settings.
    for (int phase = 0; phase < 10; phase++) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      set_area(w, h);
      r = $urandom_range(0, 3);
      write_reg(gwdm_pkg::REG_PENALTY, (r == 0) ? 16'd0 : (r == 1) ? 16'd1023 :
                16'($urandom_range(0, 1023)));
      r = $urandom_range(0, 3);
      write_reg(gwdm_pkg::REG_MOVE_RANGE, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                16'($urandom_range(0, 2000)));
      write_reg(gwdm_pkg::REG_HIGHLIGHT, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'd1);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      send_word(gwdm_pkg::OP_COMPUTE, 5'($urandom_range(0, w - 1)),
                5'($urandom_range(0, h - 1)), 8'd0, 1'b0, 1'b0);
      for (int n = 0; n < 18; n++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          random_cell_write($urandom_range(0, 31), $urandom_range(0, 31));
        end else if (r < 45) begin
          send_word(gwdm_pkg::OP_COMPUTE, 5'($urandom_range(0, w + 1)),
                    5'($urandom_range(0, h + 1)),
                    8'($urandom), 1'($urandom), 1'($urandom));
        end else if (r < 85) begin
          send_word(gwdm_pkg::OP_READ, 5'($urandom_range(0, w)), 5'($urandom_range(0, h)),
                    8'($urandom), 1'($urandom), 1'($urandom));
        end else if (r < 95) begin
          send_word(gwdm_pkg::OP_READ, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    8'd0, 1'b0, 1'b0);
        end else begin
          send_word(2'd3, 5'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
                    1'($urandom));
        end
      end
      settle();
    end

    in_if.valid = 1'b0;
    while (waiting_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("grid_weighted_distance_map_core: match");
    end else begin
      $display("grid_weighted_distance_map_core: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("grid_weighted_distance_map_core: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
sv/gwdm_pkg.sv
sv/gwdm_if.sv
sv/gwdm_ram.sv
sv/grid_weighted_distance_map_core.sv
test/gwdm_checker.sv
test/testbench.sv
